/* src/pba_pkg.sv */
// Shared types and field widths for the paged block allocator.
// Depends on nothing; every other file refers to it by scoped names.
package pba_pkg;

	localparam int ACTION_W = 1;
	localparam int SEQ_ID_W = 6;
	localparam int COUNT_W  = 7;
	localparam int TOTAL_W  = 13;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [SEQ_ID_W-1:0] seq_id_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [TOTAL_W-1:0]  total_t;
	typedef logic [11:0]         block_t;
	typedef logic [7:0]          slot_t;
	typedef logic [8:0]          freed_t;
	typedef logic [12:0]         free_rem_t;

	localparam action_t ACT_ALLOC   = 1'b0;
	localparam action_t ACT_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANT = 2'd0,
		ST_DONE  = 2'd1,
		ST_SHORT = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic    accept;
		logic    start;
		logic    pop;
		logic    grant;
		logic    emit;
		status_t code;
		logic    rel_read;
		logic    rel_push;
		logic    rel_finish;
	} cmd_t;

	typedef struct packed {
		logic is_rel;
		logic cnt_zero;
		logic short_pool;
		logic tab_full;
		logic rel_empty;
		logic rel_end;
		logic burst_end;
		logic out_free;
	} stat_t;

endpackage

/* src/pba_if.sv */
// Request and response channel interfaces of the paged block allocator.
// Depends on pba_pkg for the field types.
interface pba_req_if;
	logic              valid;
	logic              ready;
	pba_pkg::action_t  action;
	pba_pkg::seq_id_t  seq_id;
	pba_pkg::count_t   count;

	modport source (output valid, output action, output seq_id, output count, input ready);
	modport sink (input valid, input action, input seq_id, input count, output ready);
endinterface

interface pba_rsp_if;
	logic                valid;
	logic                ready;
	pba_pkg::status_t    status;
	pba_pkg::block_t     blk_num;
	pba_pkg::slot_t      slot;
	pba_pkg::freed_t     freed_count;
	pba_pkg::free_rem_t  free_remaining;
	logic                last;

	modport source (output valid, output status, output blk_num, output slot,
		output freed_count, output free_remaining, output last, input ready);
	modport sink (input valid, input status, input blk_num, input slot,
		input freed_count, input free_remaining, input last, output ready);
endinterface

/* src/pba_dp.sv */
// Datapath of the paged block allocator: free stack, sequence tables, counts
// and the response register. Depends on pba_pkg and pba_if.
module pba_dp #(
	parameter int POOL_BLOCKS = 4096,
	parameter int SEQ_SLOTS   = 64,
	parameter int SEQ_DEPTH   = 256,
	parameter int MAX_BURST   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  pba_pkg::total_t   cfg_wdata,
	input  pba_pkg::action_t  in_action,
	input  pba_pkg::seq_id_t  in_seq_id,
	input  pba_pkg::count_t   in_count,
	input  pba_pkg::cmd_t     cmd,
	output pba_pkg::stat_t    stat,
	pba_rsp_if.source         rsp
);

	localparam int BW   = $clog2(POOL_BLOCKS);
	localparam int TW   = $clog2(POOL_BLOCKS + 1);
	localparam int SW   = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
	localparam int PW   = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int CW   = $clog2(SEQ_DEPTH + 1);
	localparam int RW   = $clog2(MAX_BURST + 1);
	localparam int NIDS = 2 ** pba_pkg::SEQ_ID_W;
	localparam int RESET_TOTAL = (4096 > POOL_BLOCKS) ? POOL_BLOCKS : 4096;

	logic [SW-1:0] seq_map [NIDS];

	for (genvar g = 0; g < NIDS; g++) begin : g_seq_map
		assign seq_map[g] = SW'(g % SEQ_SLOTS);
	end

	logic [BW-1:0] free_mem [POOL_BLOCKS];
	logic [BW-1:0] tab_mem  [SEQ_SLOTS * (2 ** PW)];
	logic [CW-1:0] cnt_mem  [SEQ_SLOTS];
	logic [SEQ_SLOTS-1:0] cnt_vld_q;

	logic [TW-1:0] top_q;
	logic [TW-1:0] low_q;
	logic          act_q;
	logic [SW-1:0] seq_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;

	logic [CW-1:0] cnt_rd_q;
	logic          cnt_hit_q;
	logic [BW-1:0] fs_rd_q;
	logic [BW-1:0] pop_idx_q;
	logic          byp_q;
	logic [BW-1:0] tab_rd_q;

	logic                 out_valid_q;
	pba_pkg::status_t     out_status_q;
	pba_pkg::block_t      out_block_q;
	pba_pkg::slot_t       out_slot_q;
	pba_pkg::freed_t      out_freed_q;
	pba_pkg::free_rem_t   out_rem_q;
	logic                 out_last_q;

	logic [SW-1:0] seq_in;
	logic [RW-1:0] cnt_in;
	logic [CW-1:0] cur_cnt;
	logic [TW-1:0] top_dec;
	logic [BW-1:0] grant_blk;
	logic [TW-1:0] cfg_total;
	logic          push_ok;
	logic          out_load;

	always_comb begin
		seq_in    = seq_map[in_seq_id];
		cnt_in    = (in_count > pba_pkg::count_t'(MAX_BURST)) ? RW'(MAX_BURST) : RW'(in_count);
		cur_cnt   = cnt_hit_q ? cnt_rd_q : '0;
		top_dec   = top_q - TW'(1);
		grant_blk = byp_q ? pop_idx_q : fs_rd_q;
		push_ok   = 32'(top_q) < 32'(POOL_BLOCKS);
		out_load  = cmd.grant || cmd.emit || cmd.rel_finish;
		if (cfg_wdata == '0) begin
			cfg_total = TW'(1);
		end else if (32'(cfg_wdata) > 32'(POOL_BLOCKS)) begin
			cfg_total = TW'(POOL_BLOCKS);
		end else begin
			cfg_total = TW'(cfg_wdata);
		end
	end

	always_comb begin
		stat.is_rel     = act_q;
		stat.cnt_zero   = rem_q == '0;
		stat.short_pool = 32'(top_q) < 32'(rem_q);
		stat.tab_full   = (32'(cur_cnt) + 32'(rem_q)) > 32'(SEQ_DEPTH);
		stat.rel_empty  = cur_cnt == '0;
		stat.rel_end    = (idx_q + CW'(1)) == pos_q;
		stat.burst_end  = rem_q == RW'(1);
		stat.out_free   = !out_valid_q || rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= TW'(RESET_TOTAL);
			low_q     <= TW'(POOL_BLOCKS);
			cnt_vld_q <= '0;
		end else if (cfg_we) begin
			top_q     <= cfg_total;
			low_q     <= TW'(POOL_BLOCKS);
			cnt_vld_q <= '0;
		end else begin
			if (cmd.pop) begin
				top_q <= top_dec;
			end
			if (cmd.rel_push && push_ok) begin
				top_q <= top_q + TW'(1);
				if (top_q < low_q) begin
					low_q <= top_q;
				end
			end
			if (cmd.grant) begin
				cnt_vld_q[seq_q] <= 1'b1;
			end
			if (cmd.rel_finish) begin
				cnt_vld_q[seq_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q     <= (in_action == pba_pkg::ACT_RELEASE);
			seq_q     <= seq_in;
			rem_q     <= cnt_in;
			cnt_rd_q  <= cnt_mem[seq_in];
			cnt_hit_q <= cnt_vld_q[seq_in];
		end
		if (cmd.start) begin
			pos_q <= cur_cnt;
			idx_q <= '0;
		end
		if (cmd.pop) begin
			fs_rd_q   <= free_mem[top_dec[BW-1:0]];
			pop_idx_q <= top_dec[BW-1:0];
			byp_q     <= top_dec < low_q;
		end
		if (cmd.grant) begin
			tab_mem[{seq_q, pos_q[PW-1:0]}] <= grant_blk;
			cnt_mem[seq_q] <= pos_q + CW'(1);
			pos_q <= pos_q + CW'(1);
			rem_q <= rem_q - RW'(1);
		end
		if (cmd.rel_read) begin
			tab_rd_q <= tab_mem[{seq_q, idx_q[PW-1:0]}];
		end
		if (cmd.rel_push) begin
			if (push_ok) begin
				free_mem[top_q[BW-1:0]] <= tab_rd_q;
			end
			idx_q <= idx_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_block_q <= '0;
			out_slot_q  <= '0;
			out_freed_q <= '0;
			out_last_q  <= 1'b1;
			if (cmd.grant) begin
				out_status_q <= pba_pkg::ST_GRANT;
				out_block_q  <= pba_pkg::block_t'(grant_blk);
				out_slot_q   <= pba_pkg::slot_t'(pos_q);
				out_rem_q    <= pba_pkg::free_rem_t'(top_q);
				out_last_q   <= rem_q == RW'(1);
			end else if (cmd.rel_finish) begin
				out_status_q <= pba_pkg::ST_DONE;
				out_freed_q  <= pba_pkg::freed_t'(pos_q);
				out_rem_q    <= pba_pkg::free_rem_t'(top_q);
			end else begin
				out_status_q <= cmd.code;
				out_rem_q    <= pba_pkg::free_rem_t'(top_q);
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.blk_num        = out_block_q;
	assign rsp.slot           = out_slot_q;
	assign rsp.freed_count    = out_freed_q;
	assign rsp.free_remaining = out_rem_q;
	assign rsp.last           = out_last_q;

endmodule

/* src/pba_ctrl.sv */
// Controller state machine of the paged block allocator.
// Depends on pba_pkg for the command and status structs.
module pba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pba_pkg::stat_t  stat,
	output pba_pkg::cmd_t   cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_LOOKUP   = 7'b0000010,
		S_POP      = 7'b0000100,
		S_GRANT    = 7'b0001000,
		S_REL_RD   = 7'b0010000,
		S_REL_WR   = 7'b0100000,
		S_REL_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.code = pba_pkg::ST_DONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (stat.is_rel) begin
					if (!stat.rel_empty) begin
						cmd.start = 1'b1;
						state_d   = S_REL_RD;
					end else if (stat.out_free) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (stat.cnt_zero || stat.short_pool || stat.tab_full) begin
					if (stat.cnt_zero) begin
						cmd.code = pba_pkg::ST_DONE;
					end else if (stat.short_pool) begin
						cmd.code = pba_pkg::ST_SHORT;
					end else begin
						cmd.code = pba_pkg::ST_FULL;
					end
					if (stat.out_free) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end
				end else begin
					cmd.start = 1'b1;
					state_d   = S_POP;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_GRANT;
			end
			S_GRANT: begin
				if (stat.out_free) begin
					cmd.grant = 1'b1;
					state_d   = stat.burst_end ? S_IDLE : S_POP;
				end
			end
			S_REL_RD: begin
				cmd.rel_read = 1'b1;
				state_d      = S_REL_WR;
			end
			S_REL_WR: begin
				cmd.rel_push = 1'b1;
				state_d      = stat.rel_end ? S_REL_DONE : S_REL_RD;
			end
			S_REL_DONE: begin
				if (stat.out_free) begin
					cmd.rel_finish = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/paged_block_allocator.sv */
// Top level of the paged block allocator: controller and datapath.
// Depends on pba_pkg, pba_if, pba_ctrl and pba_dp.
// An allocate request first looks up the sequence's block count, then for each granted block
// reads the free stack and then writes the table and the result; an allocate of zero
// blocks, a failed allocate or the release of an empty table gives its result after the
// lookup. A release reads the table and writes the free stack for each returned block,
// then gives its result. Every result that finds the result register still full waits
// until that register is taken. The result register lets a new request enter while the
// last result still waits. Writing total_blocks is registered with no clearing pass; the
// user must write it only while the block is idle, which the block itself does not enforce.
module paged_block_allocator #(
	parameter int POOL_BLOCKS = 4096,
	parameter int SEQ_SLOTS   = 64,
	parameter int SEQ_DEPTH   = 256,
	parameter int MAX_BURST   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  pba_pkg::total_t  cfg_wdata,
	pba_req_if.sink          req,
	pba_rsp_if.source        rsp
);

	pba_pkg::cmd_t  cmd;
	pba_pkg::stat_t stat;
	logic           in_ready;

	pba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pba_dp #(
		.POOL_BLOCKS (POOL_BLOCKS),
		.SEQ_SLOTS   (SEQ_SLOTS),
		.SEQ_DEPTH   (SEQ_DEPTH),
		.MAX_BURST   (MAX_BURST)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_action (req.action),
		.in_seq_id (req.seq_id),
		.in_count  (req.count),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

	assign req.ready = in_ready;

endmodule
